>>> rtl/tls_client_hello_parser_assert.svh
// ----------------------------------------------------------------------------
// TLS ClientHello parser assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TLS_CLIENT_HELLO_PARSER_ASSERT_SVH
`define TLS_CLIENT_HELLO_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLSCH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TLSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLSCH_ASSERT_IMP(lbl, ante, cons, msg)
`define TLSCH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/tlsch_pkg.sv
// ----------------------------------------------------------------------------
// TLS ClientHello parser package
// Parse phases, mode and status codes, and the result record type.
// ----------------------------------------------------------------------------
package tlsch_pkg;

    localparam int SESSION_DEPTH = 32;
    localparam int SESS_AW       = 5;

    localparam logic [1:0] MODE_STREAM    = 2'd0;
    localparam logic [1:0] MODE_READ_SESS = 2'd1;
    localparam logic [1:0] MODE_READ_HOST = 2'd2;
    localparam logic [1:0] MODE_RESTART   = 2'd3;

    localparam logic [1:0] ST_HELLO   = 2'd0;
    localparam logic [1:0] ST_OTHER   = 2'd1;
    localparam logic [1:0] ST_GAVE_UP = 2'd2;

    localparam logic [15:0] MAX_LEN_RESET = 16'd16389;
    localparam logic [15:0] MIN_RECORD    = 16'd6;
    localparam logic [15:0] EXT_SNI       = 16'd0;
    localparam logic [15:0] EXT_TICKET    = 16'd35;
    localparam logic [7:0]  VER_MAJOR     = 8'h03;
    localparam logic [7:0]  HS_CLIENT     = 8'h01;
    localparam logic [15:0] RANDOM_LEN    = 16'd32;

    typedef enum logic [27:0] {
        PH_HDR         = 28'b1 << 0,
        PH_HS_TYPE     = 28'b1 << 1,
        PH_HS_LEN      = 28'b1 << 2,
        PH_VER_MAJ     = 28'b1 << 3,
        PH_VER_MIN     = 28'b1 << 4,
        PH_OTHER       = 28'b1 << 5,
        PH_RANDOM      = 28'b1 << 6,
        PH_SESS_LEN    = 28'b1 << 7,
        PH_SESS        = 28'b1 << 8,
        PH_CIPH_HI     = 28'b1 << 9,
        PH_CIPH_LO     = 28'b1 << 10,
        PH_CIPH        = 28'b1 << 11,
        PH_COMP_LEN    = 28'b1 << 12,
        PH_COMP        = 28'b1 << 13,
        PH_EXTS_HI     = 28'b1 << 14,
        PH_EXTS_LO     = 28'b1 << 15,
        PH_EXT_TYPE_HI = 28'b1 << 16,
        PH_EXT_TYPE_LO = 28'b1 << 17,
        PH_EXT_LEN_HI  = 28'b1 << 18,
        PH_EXT_LEN_LO  = 28'b1 << 19,
        PH_X_SKIP      = 28'b1 << 20,
        PH_X_LIST_HI   = 28'b1 << 21,
        PH_X_LIST_LO   = 28'b1 << 22,
        PH_X_NTYPE     = 28'b1 << 23,
        PH_X_NLEN_HI   = 28'b1 << 24,
        PH_X_NLEN_LO   = 28'b1 << 25,
        PH_X_NAME      = 28'b1 << 26,
        PH_DONE        = 28'b1 << 27
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [5:0] session_len;
        logic [7:0] hostname_len;
        logic       has_ticket;
        logic       sel_host;
        logic       zero;
    } res_t;

    // pick the next server name entry, or skip the rest of the extension
    function automatic phase_t enter_entry(logic [15:0] list_rem, logic [15:0] ext_rem);
        return (list_rem == 16'd0 || ext_rem < 16'd3) ? PH_X_SKIP : PH_X_NTYPE;
    endfunction

endpackage

>>> rtl/tlsch_if.sv
// ----------------------------------------------------------------------------
// TLS ClientHello parser channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tlsch_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] read_index;

    modport source (output valid, mode, data_byte, read_index, input ready);
    modport sink   (input valid, mode, data_byte, read_index, output ready);
endinterface

interface tlsch_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] status;
    logic [5:0] session_len;
    logic [7:0] hostname_len;
    logic       has_ticket;
    logic [7:0] read_value;

    modport source (output valid, kind, status, session_len, hostname_len, has_ticket,
                    read_value, input ready);
    modport sink   (input valid, kind, status, session_len, hostname_len, has_ticket,
                    read_value, output ready);
endinterface

>>> rtl/tlsch_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tls_client_hello_parser.sv
// Results pass through the result stage register, then the output register. One item
// is taken per cycle unless results stall; the parse state updates in the accepting cycle
// and the store read port is registered, so stream bytes and readbacks interleave freely.
// Reset clears parse state, counters, pipeline valids and max_len_reg (16389);
// the session id and hostname stores are not cleared and read undefined until written.
// ----------------------------------------------------------------------------
// TLS ClientHello parser
// Walks the first TLS record byte by byte, captures session id and SNI hostname.
// ----------------------------------------------------------------------------
`include "tls_client_hello_parser_assert.svh"

module tls_client_hello_parser
    import tlsch_pkg::*;
#(
    parameter int NAME_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    tlsch_in_if.sink      item,
    tlsch_out_if.source   result
);

    localparam int          HOST_AW    = $clog2(NAME_DEPTH);
    localparam logic [16:0] NAME_LIMIT = 17'(NAME_DEPTH);

    phase_t      phase_reg, phase_next;
    logic [15:0] max_len_reg;
    logic [15:0] byte_cnt_reg, byte_cnt_next;
    logic [15:0] rec_len_reg, rec_len_next;
    logic [15:0] field_rem_reg, field_rem_next;
    logic [15:0] ext_rem_reg, ext_rem_next;
    logic [15:0] list_rem_reg, list_rem_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] ext_kind_reg, ext_kind_next;
    logic [5:0]  sess_cnt_reg, sess_cnt_next;
    logic [15:0] host_cnt_reg, host_cnt_next;
    logic        ticket_reg, ticket_next;

    logic        s1_valid_reg;
    res_t        s1_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    logic [7:0]  out_value_reg;

    logic               acc, s1_adv;
    logic               res_v;
    res_t               res;
    logic               sess_we, sess_re, host_we, host_re;
    logic [SESS_AW-1:0] sess_waddr;
    logic [HOST_AW-1:0] host_waddr;
    logic [7:0]         sess_rdata, host_rdata;
    logic [16:0]        idx_wide;

    assign acc      = item.valid && item.ready;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign idx_wide = {9'd0, item.read_index};

    // next parse state and result for the transfer in hand
    always_comb
    begin
        logic [15:0] v16;
        logic [15:0] er_d, lr_d;
        logic [5:0]  v6;
        logic [7:0]  b;
        logic        fail, last, ext_body, verdict;
        logic [1:0]  vstat;

        b     = item.data_byte;
        er_d  = ext_rem_reg - 16'd1;
        lr_d  = (list_rem_reg != 16'd0) ? list_rem_reg - 16'd1 : list_rem_reg;
        v16   = 16'd0;
        v6    = 6'd0;
        fail  = 1'b0;
        last  = 1'b0;
        ext_body = 1'b0;
        verdict  = 1'b0;
        vstat    = ST_GAVE_UP;

        phase_next     = phase_reg;
        byte_cnt_next  = byte_cnt_reg;
        rec_len_next   = rec_len_reg;
        field_rem_next = field_rem_reg;
        ext_rem_next   = ext_rem_reg;
        list_rem_next  = list_rem_reg;
        held_next      = held_reg;
        ext_kind_next  = ext_kind_reg;
        sess_cnt_next  = sess_cnt_reg;
        host_cnt_next  = host_cnt_reg;
        ticket_next    = ticket_reg;

        res_v      = 1'b0;
        res        = '0;
        sess_we    = 1'b0;
        sess_re    = 1'b0;
        host_we    = 1'b0;
        host_re    = 1'b0;
        sess_waddr = '0;
        host_waddr = '0;

        if (acc)
        begin
            unique case (item.mode)
                MODE_RESTART:
                begin
                    phase_next     = PH_HDR;
                    byte_cnt_next  = '0;
                    rec_len_next   = '0;
                    field_rem_next = '0;
                    ext_rem_next   = '0;
                    list_rem_next  = '0;
                    held_next      = '0;
                    ext_kind_next  = '0;
                    sess_cnt_next  = '0;
                    host_cnt_next  = '0;
                    ticket_next    = 1'b0;
                end
                MODE_READ_SESS:
                begin
                    sess_re  = 1'b1;
                    res_v    = 1'b1;
                    res.kind = 1'b1;
                    res.sel_host = 1'b0;
                    res.zero = !(idx_wide < {11'd0, sess_cnt_reg} &&
                                 idx_wide < 17'(SESSION_DEPTH));
                end
                MODE_READ_HOST:
                begin
                    host_re  = 1'b1;
                    res_v    = 1'b1;
                    res.kind = 1'b1;
                    res.sel_host = 1'b1;
                    res.zero = !(idx_wide < {1'b0, host_cnt_reg} && idx_wide < NAME_LIMIT);
                end
                default:
                begin
                    if (phase_reg == PH_DONE)
                    begin
                        // ignore stream bytes until restart
                    end
                    else if (phase_reg == PH_HDR)
                    begin
                        // record header: type, version, length
                        byte_cnt_next = byte_cnt_reg + 16'd1;
                        if (byte_cnt_reg == 16'd0)
                        begin
                            if (b < 8'd20 || b > 8'd23)
                            begin
                                verdict = 1'b1;
                            end
                        end
                        else if (byte_cnt_reg == 16'd3)
                        begin
                            held_next = b;
                        end
                        else if (byte_cnt_reg == 16'd4)
                        begin
                            v16 = {held_reg, b};
                            rec_len_next = v16;
                            if (v16 >= max_len_reg || v16 < MIN_RECORD)
                            begin
                                verdict = 1'b1;
                            end
                            else
                            begin
                                phase_next    = PH_HS_TYPE;
                                byte_cnt_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        last          = (byte_cnt_reg + 16'd1) == rec_len_reg;
                        byte_cnt_next = byte_cnt_reg + 16'd1;
                        unique case (phase_reg)
                            PH_HS_TYPE:
                            begin
                                held_next      = b;
                                field_rem_next = 16'd3;
                                phase_next     = PH_HS_LEN;
                            end
                            PH_HS_LEN:
                            begin
                                field_rem_next = field_rem_reg - 16'd1;
                                if (field_rem_next == 16'd0)
                                    phase_next = PH_VER_MAJ;
                            end
                            PH_VER_MAJ:
                            begin
                                if (b != VER_MAJOR)
                                    fail = 1'b1;
                                else
                                    phase_next = PH_VER_MIN;
                            end
                            PH_VER_MIN:
                            begin
                                if (b < 8'd1 || b > 8'd3)
                                    fail = 1'b1;
                                else if (held_reg == HS_CLIENT)
                                begin
                                    field_rem_next = RANDOM_LEN;
                                    phase_next     = PH_RANDOM;
                                end
                                else
                                    phase_next = PH_OTHER;
                            end
                            PH_RANDOM:
                            begin
                                field_rem_next = field_rem_reg - 16'd1;
                                if (field_rem_next == 16'd0)
                                    phase_next = PH_SESS_LEN;
                            end
                            PH_SESS_LEN:
                            begin
                                if (b > 8'(SESSION_DEPTH))
                                    fail = 1'b1;
                                else
                                begin
                                    sess_cnt_next  = b[5:0];
                                    field_rem_next = {8'd0, b};
                                    phase_next     = (b != 8'd0) ? PH_SESS : PH_CIPH_HI;
                                end
                            end
                            PH_SESS:
                            begin
                                v6 = sess_cnt_reg - field_rem_reg[5:0];
                                if (v6 < 6'(SESSION_DEPTH))
                                begin
                                    sess_we    = 1'b1;
                                    sess_waddr = v6[SESS_AW-1:0];
                                end
                                field_rem_next = field_rem_reg - 16'd1;
                                if (field_rem_next == 16'd0)
                                    phase_next = PH_CIPH_HI;
                            end
                            PH_CIPH_HI:
                            begin
                                held_next  = b;
                                phase_next = PH_CIPH_LO;
                            end
                            PH_EXT_TYPE_HI:
                            begin
                                held_next  = b;
                                phase_next = PH_EXT_TYPE_LO;
                            end
                            PH_EXT_LEN_HI:
                            begin
                                held_next  = b;
                                phase_next = PH_EXT_LEN_LO;
                            end
                            PH_CIPH_LO:
                            begin
                                field_rem_next = {held_reg, b};
                                phase_next = (field_rem_next != 16'd0) ? PH_CIPH : PH_COMP_LEN;
                            end
                            PH_CIPH:
                            begin
                                field_rem_next = field_rem_reg - 16'd1;
                                if (field_rem_next == 16'd0)
                                    phase_next = PH_COMP_LEN;
                            end
                            PH_COMP:
                            begin
                                field_rem_next = field_rem_reg - 16'd1;
                                if (field_rem_next == 16'd0)
                                    phase_next = PH_EXTS_HI;
                            end
                            PH_COMP_LEN:
                            begin
                                field_rem_next = {8'd0, b};
                                phase_next = (b != 8'd0) ? PH_COMP : PH_EXTS_HI;
                            end
                            PH_EXTS_HI:
                                phase_next = PH_EXTS_LO;
                            PH_EXTS_LO:
                                phase_next = PH_EXT_TYPE_HI;
                            PH_EXT_TYPE_LO:
                            begin
                                ext_kind_next = {held_reg, b};
                                phase_next    = PH_EXT_LEN_HI;
                            end
                            PH_EXT_LEN_LO:
                            begin
                                v16          = {held_reg, b};
                                ext_rem_next = v16;
                                phase_next   = PH_X_SKIP;
                                if (ext_kind_reg == EXT_TICKET)
                                    ticket_next = (v16 != 16'd0);
                                else if (ext_kind_reg == EXT_SNI && v16 >= 16'd2)
                                    phase_next = PH_X_LIST_HI;
                                if (v16 == 16'd0)
                                    phase_next = PH_EXT_TYPE_HI;
                            end
                            PH_X_SKIP:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                            end
                            PH_X_LIST_HI:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                                held_next     = b;
                                phase_next    = PH_X_LIST_LO;
                            end
                            PH_X_LIST_LO:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                                v16 = {held_reg, b};
                                if (v16 > er_d)
                                    phase_next = PH_X_SKIP;
                                else
                                begin
                                    list_rem_next = v16;
                                    phase_next    = enter_entry(v16, er_d);
                                end
                            end
                            PH_X_NTYPE:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                                phase_next    = (b != 8'd0) ? PH_X_SKIP : PH_X_NLEN_HI;
                            end
                            PH_X_NLEN_HI:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                                held_next     = b;
                                phase_next    = PH_X_NLEN_LO;
                            end
                            PH_X_NLEN_LO:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                                v16 = {held_reg, b};
                                if (v16 > er_d)
                                    phase_next = PH_X_SKIP;
                                else
                                begin
                                    host_cnt_next  = v16;
                                    field_rem_next = v16;
                                    phase_next = (v16 == 16'd0) ? enter_entry(lr_d, er_d)
                                                                : PH_X_NAME;
                                end
                            end
                            PH_X_NAME:
                            begin
                                ext_body      = 1'b1;
                                ext_rem_next  = er_d;
                                list_rem_next = lr_d;
                                v16 = host_cnt_reg - field_rem_reg;
                                if ({1'b0, v16} < NAME_LIMIT)
                                begin
                                    host_we    = 1'b1;
                                    host_waddr = v16[HOST_AW-1:0];
                                end
                                field_rem_next = field_rem_reg - 16'd1;
                                if (field_rem_next == 16'd0)
                                    phase_next = enter_entry(lr_d, er_d);
                            end
                            default:
                            begin
                                // handshake other than ClientHello: count bytes only
                            end
                        endcase

                        // extension body used up
                        if (ext_body && er_d == 16'd0)
                            phase_next = PH_EXT_TYPE_HI;

                        if (fail)
                            verdict = 1'b1;
                        else if (last)
                        begin
                            verdict = 1'b1;
                            if (phase_next == PH_OTHER)
                                vstat = ST_OTHER;
                            else if (phase_next == PH_EXTS_HI || phase_next == PH_EXT_TYPE_HI)
                                vstat = ST_HELLO;
                        end
                    end

                    if (verdict)
                    begin
                        phase_next = PH_DONE;
                        res_v      = 1'b1;
                        res.kind   = 1'b0;
                        res.status = vstat;
                        res.zero   = 1'b1;
                    end
                end
            endcase
            res.session_len  = sess_cnt_next;
            res.hostname_len = host_cnt_next[7:0];
            res.has_ticket   = ticket_next;
        end
    end

    // parse state and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            max_len_reg   <= MAX_LEN_RESET;
            byte_cnt_reg  <= '0;
            rec_len_reg   <= '0;
            field_rem_reg <= '0;
            ext_rem_reg   <= '0;
            list_rem_reg  <= '0;
            held_reg      <= '0;
            ext_kind_reg  <= '0;
            sess_cnt_reg  <= '0;
            host_cnt_reg  <= '0;
            ticket_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            phase_reg     <= phase_next;
            byte_cnt_reg  <= byte_cnt_next;
            rec_len_reg   <= rec_len_next;
            field_rem_reg <= field_rem_next;
            ext_rem_reg   <= ext_rem_next;
            list_rem_reg  <= list_rem_next;
            held_reg      <= held_next;
            ext_kind_reg  <= ext_kind_next;
            sess_cnt_reg  <= sess_cnt_next;
            host_cnt_reg  <= host_cnt_next;
            ticket_reg    <= ticket_next;
        end
    end

    // stores for session id and hostname
    tlsch_ram #(.WIDTH(8), .DEPTH(SESSION_DEPTH)) u_sess_ram (
        .clk   (clk),
        .we    (sess_we),
        .waddr (sess_waddr),
        .wdata (item.data_byte),
        .re    (sess_re),
        .raddr (item.read_index[SESS_AW-1:0]),
        .rdata (sess_rdata)
    );

    tlsch_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_host_ram (
        .clk   (clk),
        .we    (host_we),
        .waddr (host_waddr),
        .wdata (item.data_byte),
        .re    (host_re),
        .raddr (idx_wide[HOST_AW-1:0]),
        .rdata (host_rdata)
    );

    // result stage waiting on the store read, then output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
                s1_valid_reg <= res_v;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (acc && res_v)
            s1_reg <= res;
        if (s1_adv)
        begin
            out_reg <= s1_reg;
            if (s1_reg.zero)
                out_value_reg <= 8'd0;
            else if (s1_reg.sel_host)
                out_value_reg <= host_rdata;
            else
                out_value_reg <= sess_rdata;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_reg.kind;
    assign result.status       = out_reg.status;
    assign result.session_len  = out_reg.session_len;
    assign result.hostname_len = out_reg.hostname_len;
    assign result.has_ticket   = out_reg.has_ticket;
    assign result.read_value   = out_value_reg;

    // checks
    `TLSCH_ASSERT_IMP(a_sess_bound, 1'b1, sess_cnt_reg <= 6'd32, "session count beyond store")
    `TLSCH_ASSERT_NEXT(a_done_holds,
        phase_reg == PH_DONE && !(acc && item.mode == MODE_RESTART),
        phase_reg == PH_DONE, "left done phase without restart")
    `TLSCH_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s1_adv, s1_valid_reg,
        "pending result dropped")

endmodule

>>> dv/tlsch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLS ClientHello parser checker
// Watches the item, result and register channels, keeps its own model of the
// record walk and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tlsch_checker
    import tlsch_pkg::*;
#(
    parameter int NAME_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    tlsch_in_if         item,
    tlsch_out_if        result,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [5:0] slen;
        logic [7:0] hlen;
        logic       tick;
        logic [7:0] val;
    } outcome_t;

    outcome_t    outcome_q[$];

    // parse state of the record walk
    phase_t      ph;
    logic [15:0] frame_limit;
    logic [15:0] cnt;
    logic [15:0] rlen;
    logic [15:0] frem;
    logic [15:0] xrem;
    logic [15:0] lrem;
    logic [7:0]  held;
    logic [15:0] xkind;
    logic [5:0]  scount;
    logic [15:0] hcount;
    logic        tick;
    logic [7:0]  sess_mem [SESSION_DEPTH];
    logic [7:0]  host_mem [NAME_DEPTH];

    task automatic report(string what, int want, int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    function automatic void restart_walk();
        ph     = PH_HDR;
        cnt    = '0;
        rlen   = '0;
        frem   = '0;
        xrem   = '0;
        lrem   = '0;
        held   = '0;
        xkind  = '0;
        scount = '0;
        hcount = '0;
        tick   = 1'b0;
    endfunction

    function automatic outcome_t snapshot(logic kind, logic [1:0] status, logic [7:0] val);
        outcome_t r;
        r.kind   = kind;
        r.status = status;
        r.slen   = scount;
        r.hlen   = hcount[7:0];
        r.tick   = tick;
        r.val    = val;
        return r;
    endfunction

    function automatic outcome_t conclude(logic [1:0] status);
        ph = PH_DONE;
        return snapshot(1'b0, status, 8'd0);
    endfunction

    // next server name entry, or skip the rest of the extension
    function automatic phase_t next_entry();
        return (lrem == 16'd0 || xrem < 16'd3) ? PH_X_SKIP : PH_X_NTYPE;
    endfunction

    // one byte inside an extension body
    function automatic void ext_byte(logic [7:0] b);
        logic [15:0] v;
        xrem = xrem - 16'd1;
        if (lrem > 0)
            lrem = lrem - 16'd1;
        case (ph)
            PH_X_LIST_HI:
            begin
                held = b;
                ph   = PH_X_LIST_LO;
            end
            PH_X_LIST_LO:
            begin
                v = {held, b};
                if (v > xrem)
                    ph = PH_X_SKIP;
                else
                begin
                    lrem = v;
                    ph   = next_entry();
                end
            end
            PH_X_NTYPE:
                ph = (b != 8'd0) ? PH_X_SKIP : PH_X_NLEN_HI;
            PH_X_NLEN_HI:
            begin
                held = b;
                ph   = PH_X_NLEN_LO;
            end
            PH_X_NLEN_LO:
            begin
                v = {held, b};
                if (v > xrem)
                    ph = PH_X_SKIP;
                else
                begin
                    hcount = v;
                    frem   = v;
                    ph     = (v == 16'd0) ? next_entry() : PH_X_NAME;
                end
            end
            PH_X_NAME:
            begin
                v = hcount - frem;
                if (v < NAME_DEPTH)
                    host_mem[v] = b;
                frem = frem - 16'd1;
                if (frem == 16'd0)
                    ph = next_entry();
            end
            default: ;
        endcase
        if (xrem == 16'd0)
            ph = PH_EXT_TYPE_HI;
    endfunction

    // one handshake body byte; false when the parse gives up at once
    function automatic bit body_byte(logic [7:0] b);
        logic [15:0] v;
        case (ph)
            PH_HS_TYPE:
            begin
                held = b;
                frem = 16'd3;
                ph   = PH_HS_LEN;
            end
            PH_HS_LEN:
            begin
                frem = frem - 16'd1;
                if (frem == 16'd0)
                    ph = PH_VER_MAJ;
            end
            PH_VER_MAJ:
            begin
                if (b != VER_MAJOR)
                    return 1'b0;
                ph = PH_VER_MIN;
            end
            PH_VER_MIN:
            begin
                if (b < 8'd1 || b > 8'd3)
                    return 1'b0;
                if (held == HS_CLIENT)
                begin
                    frem = RANDOM_LEN;
                    ph   = PH_RANDOM;
                end
                else
                    ph = PH_OTHER;
            end
            PH_RANDOM:
            begin
                frem = frem - 16'd1;
                if (frem == 16'd0)
                    ph = PH_SESS_LEN;
            end
            PH_SESS_LEN:
            begin
                if (b > SESSION_DEPTH)
                    return 1'b0;
                scount = b[5:0];
                frem   = {8'd0, b};
                ph     = (b != 8'd0) ? PH_SESS : PH_CIPH_HI;
            end
            PH_SESS:
            begin
                v = {10'd0, scount - frem[5:0]};
                if (v < SESSION_DEPTH)
                    sess_mem[v[4:0]] = b;
                frem = frem - 16'd1;
                if (frem == 16'd0)
                    ph = PH_CIPH_HI;
            end
            PH_CIPH_HI:
            begin
                held = b;
                ph   = PH_CIPH_LO;
            end
            PH_EXT_TYPE_HI:
            begin
                held = b;
                ph   = PH_EXT_TYPE_LO;
            end
            PH_EXT_LEN_HI:
            begin
                held = b;
                ph   = PH_EXT_LEN_LO;
            end
            PH_CIPH_LO:
            begin
                frem = {held, b};
                ph   = (frem != 16'd0) ? PH_CIPH : PH_COMP_LEN;
            end
            PH_CIPH, PH_COMP:
            begin
                frem = frem - 16'd1;
                if (frem == 16'd0)
                    ph = (ph == PH_CIPH) ? PH_COMP_LEN : PH_EXTS_HI;
            end
            PH_COMP_LEN:
            begin
                frem = {8'd0, b};
                ph   = (b != 8'd0) ? PH_COMP : PH_EXTS_HI;
            end
            PH_EXTS_HI:
                ph = PH_EXTS_LO;
            PH_EXTS_LO:
                ph = PH_EXT_TYPE_HI;
            PH_EXT_TYPE_LO:
            begin
                xkind = {held, b};
                ph    = PH_EXT_LEN_HI;
            end
            PH_EXT_LEN_LO:
            begin
                v    = {held, b};
                xrem = v;
                ph   = PH_X_SKIP;
                if (xkind == EXT_TICKET)
                    tick = (v != 16'd0);
                else if (xkind == EXT_SNI && v >= 16'd2)
                    ph = PH_X_LIST_HI;
                if (v == 16'd0)
                    ph = PH_EXT_TYPE_HI;
            end
            PH_X_SKIP, PH_X_LIST_HI, PH_X_LIST_LO, PH_X_NTYPE,
            PH_X_NLEN_HI, PH_X_NLEN_LO, PH_X_NAME:
                ext_byte(b);
            default: ;
        endcase
        return 1'b1;
    endfunction

    // advance the walk by one item; true when it yields a result
    function automatic bit walk_item(logic [1:0] mode, logic [7:0] b, logic [7:0] idx,
                                     output outcome_t r);
        logic last;
        logic [7:0] v;
        r = '0;
        case (mode)
            MODE_RESTART:
            begin
                restart_walk();
                return 1'b0;
            end
            MODE_READ_SESS:
            begin
                v = ({2'd0, idx} < {2'd0, scount} && idx < SESSION_DEPTH) ?
                    sess_mem[idx[4:0]] : 8'd0;
                r = snapshot(1'b1, ST_HELLO, v);
                return 1'b1;
            end
            MODE_READ_HOST:
            begin
                v = ({8'd0, idx} < hcount && idx < NAME_DEPTH) ? host_mem[idx] : 8'd0;
                r = snapshot(1'b1, ST_HELLO, v);
                return 1'b1;
            end
            default: ;
        endcase
        if (ph == PH_DONE)
            return 1'b0;
        // record header
        if (ph == PH_HDR)
        begin
            case (cnt)
                16'd0:
                    if (b < 8'd20 || b > 8'd23)
                    begin
                        r = conclude(ST_GAVE_UP);
                        return 1'b1;
                    end
                16'd3:
                    held = b;
                16'd4:
                begin
                    rlen = {held, b};
                    if (rlen >= frame_limit || rlen < MIN_RECORD)
                    begin
                        r = conclude(ST_GAVE_UP);
                        return 1'b1;
                    end
                    ph  = PH_HS_TYPE;
                    cnt = '0;
                    return 1'b0;
                end
                default: ;
            endcase
            cnt = cnt + 16'd1;
            return 1'b0;
        end
        last = (cnt + 16'd1) == rlen;
        cnt  = cnt + 16'd1;
        if (!body_byte(b))
        begin
            r = conclude(ST_GAVE_UP);
            return 1'b1;
        end
        if (last)
        begin
            if (ph == PH_OTHER)
                r = conclude(ST_OTHER);
            else if (ph == PH_EXTS_HI || ph == PH_EXT_TYPE_HI)
                r = conclude(ST_HELLO);
            else
                r = conclude(ST_GAVE_UP);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // compare result transfers, then predict from item transfers
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            restart_walk();
            frame_limit = MAX_LEN_RESET;
            outcome_q.delete();
            foreach (sess_mem[i]) sess_mem[i] = '0;
            foreach (host_mem[i]) host_mem[i] = '0;
        end
        else
        begin
            if (cfg_we)
                frame_limit = cfg_wdata;
            if (result.valid && result.ready)
            begin
                got.kind   = result.kind;
                got.status = result.status;
                got.slen   = result.session_len;
                got.hlen   = result.hostname_len;
                got.tick   = result.has_ticket;
                got.val    = result.read_value;
                if (outcome_q.size() == 0)
                    report("result with nothing outstanding", 0, 1);
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.kind !== want.kind)
                        report("kind", want.kind, got.kind);
                    if (got.status !== want.status)
                        report("status", want.status, got.status);
                    if (got.slen !== want.slen)
                        report("session_len", want.slen, got.slen);
                    if (got.hlen !== want.hlen)
                        report("hostname_len", want.hlen, got.hlen);
                    if (got.tick !== want.tick)
                        report("has_ticket", want.tick, got.tick);
                    if (got.val !== want.val)
                        report("read_value", want.val, got.val);
                end
            end
            if (item.valid && item.ready)
                if (walk_item(item.mode, item.data_byte, item.read_index, want))
                    outcome_q.push_back(want);
        end
        pending = outcome_q.size();
    end

endmodule

>>> dv/tls_client_hello_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLS ClientHello parser testbench
// Streams TLS records, mostly well-formed ClientHellos with random content and
// some broken ones, with readbacks and restarts mixed in, across several frame
// length limits. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module tls_client_hello_parser_tb;
    import tlsch_pkg::*;

    localparam int ITEMS      = 1950;
    localparam int IDLE_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          errors;
    int          pending;
    int          sent;
    int          idle;
    bit          hold_req;
    bit          calm;
    logic [7:0]  rec [$];
    logic [7:0]  ext [$];

    tlsch_in_if  in_ch ();
    tlsch_out_if out_ch ();

    tls_client_hello_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (in_ch),
        .result    (out_ch)
    );

    tlsch_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (in_ch),
        .result    (out_ch),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // abort when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle <= 0;
        else
        begin
            idle <= idle + 1;
            if (idle == IDLE_LIMIT)
            begin
                $display("** tls_client_hello_parser: FAILED **");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(15, 60)
                                                  : $urandom_range(1, 3)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item and hold it until transferred
    task automatic send(logic [1:0] mode, logic [7:0] b, logic [7:0] idx);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.data_byte  <= b;
        in_ch.read_index <= idx;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic readback();
        send($urandom_range(0, 1) ? MODE_READ_SESS : MODE_READ_HOST, 8'($urandom),
             8'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255)));
    endtask

    task automatic restart();
        send(MODE_RESTART, 8'($urandom), 8'($urandom));
    endtask

    // stream the built record, then restart the parse
    task automatic play(bit reads);
        foreach (rec[i])
        begin
            if (reads && $urandom_range(0, 11) == 0)
                readback();
            send(MODE_STREAM, rec[i], 8'($urandom));
        end
        restart();
    endtask

    // stop offering and wait until every prediction has been met
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic put16(ref logic [7:0] q[$], input logic [15:0] v);
        q.push_back(v[15:8]);
        q.push_back(v[7:0]);
    endtask

    // append one extension to the record body
    task automatic add_ext(bit fill);
        logic [15:0] t;
        logic [15:0] n16;
        int r;
        int nl;
        ext.delete();
        r = fill ? 0 : $urandom_range(0, 9);
        if (r < 5)
        begin
            t = EXT_SNI;
            if (!fill && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(0, 1)) ext.push_back(8'($urandom));
            else
            begin
                repeat (fill ? 1 : $urandom_range(1, 3))
                begin
                    ext.push_back((fill || $urandom_range(0, 9) != 0) ? 8'd0 : 8'($urandom));
                    nl = fill ? 256 : ($urandom_range(0, 19) == 0 ? $urandom_range(13, 300)
                                                                  : $urandom_range(0, 12));
                    n16 = 16'(nl);
                    if (!fill && $urandom_range(0, 14) == 0)
                        n16 = 16'(n16 + $urandom_range(1, 3));
                    put16(ext, n16);
                    repeat (nl) ext.push_back(8'($urandom));
                end
                n16 = 16'(ext.size());
                if (!fill && $urandom_range(0, 9) == 0)
                    n16 = 16'(n16 + $urandom_range(1, 3));
                ext.push_front(n16[7:0]);
                ext.push_front(n16[15:8]);
            end
        end
        else if (r < 7)
        begin
            t = EXT_TICKET;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4))
                ext.push_back(8'($urandom));
        end
        else
        begin
            t = 16'($urandom);
            repeat ($urandom_range(0, 6)) ext.push_back(8'($urandom));
        end
        put16(rec, t);
        put16(rec, 16'(ext.size()));
        foreach (ext[i]) rec.push_back(ext[i]);
    endtask

    // build one record: mostly ClientHellos, some other handshakes and junk
    task automatic make_record(bit fill);
        int k;
        int n;
        logic [7:0] hs;
        logic [15:0] len;
        rec.delete();
        k = fill ? 0 : $urandom_range(0, 9);
        if (k == 9)
            repeat ($urandom_range(0, 20)) rec.push_back(8'($urandom));
        else
        begin
            hs = HS_CLIENT;
            if (k == 7)
            begin
                hs = 8'($urandom);
                if (hs == HS_CLIENT)
                    hs = 8'd0;
            end
            rec.push_back(hs);
            repeat (3) rec.push_back(8'($urandom));
            rec.push_back((!fill && $urandom_range(0, 19) == 0) ? 8'($urandom) : VER_MAJOR);
            rec.push_back((!fill && $urandom_range(0, 19) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(1, 3)));
            if (hs != HS_CLIENT)
                repeat ($urandom_range(0, 10)) rec.push_back(8'($urandom));
            else
            begin
                repeat (32) rec.push_back(8'($urandom));
                n = fill ? 32 : ($urandom_range(0, 19) == 0 ? $urandom_range(33, 255)
                                                            : $urandom_range(0, 32));
                rec.push_back(8'(n));
                if (n <= 32)
                    repeat (n) rec.push_back(8'($urandom));
                n = $urandom_range(0, 6);
                put16(rec, 16'(n));
                repeat (n) rec.push_back(8'($urandom));
                n = $urandom_range(0, 3);
                rec.push_back(8'(n));
                repeat (n) rec.push_back(8'($urandom));
                if (fill || $urandom_range(0, 4) != 0)
                begin
                    put16(rec, 16'($urandom));
                    repeat (fill ? 1 : $urandom_range(0, 4)) add_ext(fill);
                end
            end
        end
        // record header, sometimes with a wrong length
        len = 16'(rec.size());
        if (!fill)
            case ($urandom_range(0, 19))
                0:       len = 16'($urandom_range(0, 5));
                1, 2:    len = 16'(len + $urandom_range(0, 6) - 3);
                default: ;
            endcase
        rec.push_front(len[7:0]);
        rec.push_front(len[15:8]);
        rec.push_front(8'($urandom));
        rec.push_front(8'($urandom));
        rec.push_front((fill || $urandom_range(0, 19) != 0) ? 8'($urandom_range(20, 23))
                                                            : 8'($urandom));
    endtask

    // stimulus and verdict
    initial
    begin
        logic [15:0] limits [6];
        limits = '{MAX_LEN_RESET, 16'd6, 16'hFFFF, 16'd120, 16'($urandom_range(6, 65535)),
                   16'd300};
        sent     = 0;
        hold_req = 1'b0;
        calm     = 1'b0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_STREAM;
        in_ch.data_byte  <= '0;
        in_ch.read_index <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header give-ups and readbacks with nothing stored
        send(MODE_STREAM, 8'hFF, 8'h00);
        restart();
        send(MODE_STREAM, 8'd19, 8'hFF);
        restart();
        rec = '{8'd20, 8'h03, 8'h01, 8'h00, 8'h05};
        play(0);
        rec = '{8'd23, 8'h03, 8'h03, 8'hFF, 8'hFF};
        play(0);
        send(MODE_READ_SESS, 8'hFF, 8'hFF);
        send(MODE_READ_HOST, 8'h00, 8'h00);
        send(MODE_READ_SESS, 8'h00, 8'h00);

        // fill both stores completely before any readback can reach them
        make_record(1);
        play(0);

        for (int p = 0; p < 6; p++)
        begin
            set_limit(limits[p]);
            if (p == 2)
            begin
                hold_req = 1'b1;
                repeat (40) readback();
            end
            while (sent < (p + 1) * ITEMS / 6)
            begin
                calm = ($urandom_range(0, 7) == 0);
                make_record(0);
                play(1);
            end
            calm = 1'b0;
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("** tls_client_hello_parser: PASSED **");
        else
            $display("** tls_client_hello_parser: FAILED **");
        $finish;
    end

endmodule
